/* sv/ftr_pkg.sv */
`default_nettype none

package ftr_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned GlyphRows   = 7;
  localparam int unsigned GlyphCols   = 5;
  localparam int unsigned GlyphPixels = GlyphRows * GlyphCols;

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharBang    = 8'd33;
  localparam logic [7:0] CharPlus    = 8'd43;
  localparam logic [7:0] CharDash    = 8'd45;
  localparam logic [7:0] CharDot     = 8'd46;
  localparam logic [7:0] CharSlash   = 8'd47;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharNine    = 8'd57;
  localparam logic [7:0] CharColon   = 8'd58;
  localparam logic [7:0] CharUpperA  = 8'd65;
  localparam logic [7:0] CharUpperZ  = 8'd90;
  localparam logic [7:0] CharLowerA  = 8'd97;
  localparam logic [7:0] CharLowerZ  = 8'd122;
  localparam logic [7:0] CaseFold    = 8'd32;

  localparam logic [5:0] GlyphLetterBase = 6'd10;
  localparam logic [5:0] GlyphSpace      = 6'd36;
  localparam logic [5:0] GlyphColon      = 6'd37;
  localparam logic [5:0] GlyphDot        = 6'd38;
  localparam logic [5:0] GlyphDash       = 6'd39;
  localparam logic [5:0] GlyphSlash      = 6'd40;
  localparam logic [5:0] GlyphPlus       = 6'd41;
  localparam logic [5:0] GlyphBang       = 6'd42;
  localparam logic [5:0] GlyphUnknown    = 6'd43;

  localparam logic OpBegin = 1'b0;

  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_GLYPH   = 2'd2
  } kind_e;

  typedef logic [GlyphPixels-1:0] pixels_t;

  // slice [GlyphRows-1] is the top row; bit [GlyphCols-1] of a row is the left column
  typedef logic [GlyphRows-1:0][GlyphCols-1:0] glyph_t;

  typedef struct packed {
    kind_e       kind;
    pixels_t     pixels;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  scale;
    logic [31:0] color;
  } entry_t;

  function automatic logic [5:0] glyph_index(logic [7:0] code);
    logic [7:0] c;
    logic [5:0] idx;
    c = code;
    if (code >= CharLowerA && code <= CharLowerZ) begin
      c = code - CaseFold;
    end
    if (code == CharSpace) begin
      idx = GlyphSpace;
    end else if (code >= CharZero && code <= CharNine) begin
      idx = 6'(code - CharZero);
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      idx = 6'(c - CharUpperA) + GlyphLetterBase;
    end else if (code == CharColon) begin
      idx = GlyphColon;
    end else if (code == CharDot) begin
      idx = GlyphDot;
    end else if (code == CharDash) begin
      idx = GlyphDash;
    end else if (code == CharSlash) begin
      idx = GlyphSlash;
    end else if (code == CharPlus) begin
      idx = GlyphPlus;
    end else if (code == CharBang) begin
      idx = GlyphBang;
    end else begin
      idx = GlyphUnknown;
    end
    return idx;
  endfunction

  function automatic glyph_t glyph_rom(logic [5:0] idx);
    glyph_t g;
    unique case (idx)
      6'd0:  g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      6'd1:  g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd2:  g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      6'd3:  g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      6'd4:  g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      6'd5:  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      6'd6:  g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      6'd7:  g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      6'd8:  g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      6'd9:  g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      6'd10: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd11: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      6'd12: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      6'd13: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      6'd14: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      6'd15: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd16: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      6'd17: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd18: g = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd19: g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      6'd20: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      6'd21: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      6'd22: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      6'd23: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      6'd24: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd25: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd26: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      6'd27: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      6'd28: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      6'd29: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      6'd30: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd31: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      6'd32: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      6'd33: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      6'd34: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      6'd35: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      6'd36: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0};
      6'd37: g = {5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0};
      6'd38: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      6'd39: g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      6'd40: g = {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
      6'd41: g = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
      6'd42: g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};
      default: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
    endcase
    return g;
  endfunction

  // bit (row * GlyphCols + col) set for each lit pixel, so the lowest bit comes first
  function automatic pixels_t scan_order(glyph_t g);
    pixels_t p;
    p = '0;
    for (int r = 0; r < GlyphRows; r++) begin
      for (int c = 0; c < GlyphCols; c++) begin
        p[r*GlyphCols+c] = g[GlyphRows-1-r][GlyphCols-1-c];
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* sv/ftr_front.sv */
`default_nettype none

module ftr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           op_i,
  input  wire logic [15:0]    origin_x_i,
  input  wire logic [15:0]    origin_y_i,
  input  wire logic [7:0]     pixel_scale_i,
  input  wire logic [31:0]    ink_color_i,
  input  wire logic [7:0]     char_code_i,
  input  wire logic           full_i,
  output logic                push_o,
  output ftr_pkg::entry_t     push_data_o
);
  import ftr_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   accept;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign push_data_o = entry_q;

  always_comb begin
    entry_d.pos_x  = origin_x_i;
    entry_d.pos_y  = origin_y_i;
    entry_d.scale  = pixel_scale_i;
    entry_d.color  = ink_color_i;
    entry_d.pixels = scan_order(glyph_rom(glyph_index(char_code_i)));
    if (op_i == OpBegin) begin
      entry_d.kind = KIND_BEGIN;
    end else if (char_code_i == CharNewline) begin
      entry_d.kind = KIND_NEWLINE;
    end else begin
      entry_d.kind = KIND_GLYPH;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

/* sv/ftr_fifo.sv */
`default_nettype none

module ftr_fifo #(
  parameter int unsigned Depth = ftr_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ftr_pkg::entry_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ftr_pkg::entry_t      pop_data_o,
  output logic                 empty_o
);
  import ftr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/ftr_back.sv */
`default_nettype none

module ftr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire ftr_pkg::entry_t pop_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic signed [15:0]   square_x_o,
  output logic signed [15:0]   square_y_o,
  output logic [7:0]           square_size_o,
  output logic [31:0]          square_color_o,
  output logic                 last_square_o
);
  import ftr_pkg::*;

  logic        busy_q, busy_d;
  pixels_t     mask_q, mask_d;
  logic [15:0] line_x_q, line_x_d;
  logic [15:0] cur_x_q, cur_x_d;
  logic [15:0] cur_y_q, cur_y_d;
  logic [7:0]  scale_q, scale_d;
  logic [31:0] color_q, color_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_x_q, out_y_q;
  logic [7:0]  out_size_q;
  logic [31:0] out_color_q;
  logic        out_last_q;

  logic        out_free, load_out;
  pixels_t     low, rest;
  logic [2:0]  row, col;
  logic [15:0] px, py, step6, step8;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !busy_q && !empty_i;
  assign low      = mask_q & (~mask_q + 1'b1);
  assign rest     = mask_q & ~low;
  assign step6    = {6'b0, scale_q, 2'b0} + {7'b0, scale_q, 1'b0};
  assign step8    = {5'b0, scale_q, 3'b0};

  always_comb begin
    row = '0;
    col = '0;
    for (int k = 0; k < GlyphPixels; k++) begin
      if (low[k]) begin
        row = row | 3'(k / GlyphCols);
        col = col | 3'(k % GlyphCols);
      end
    end
  end

  assign px = cur_x_q + (16'(col) * 16'(scale_q));
  assign py = cur_y_q + (16'(row) * 16'(scale_q));

  always_comb begin
    busy_d      = busy_q;
    mask_d      = mask_q;
    line_x_d    = line_x_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    scale_d     = scale_q;
    color_d     = color_q;
    load_out    = 1'b0;
    if (busy_q) begin
      if (out_free) begin
        load_out = 1'b1;
        mask_d   = rest;
        if (rest == '0) begin
          busy_d  = 1'b0;
          cur_x_d = cur_x_q + step6;
        end
      end
    end else if (pop_o) begin
      unique case (pop_data_i.kind)
        KIND_BEGIN: begin
          line_x_d = pop_data_i.pos_x;
          cur_x_d  = pop_data_i.pos_x;
          cur_y_d  = pop_data_i.pos_y;
          scale_d  = pop_data_i.scale;
          color_d  = pop_data_i.color;
        end
        KIND_NEWLINE: begin
          cur_x_d = line_x_q;
          cur_y_d = cur_y_q + step8;
        end
        KIND_GLYPH: begin
          if (pop_data_i.pixels == '0) begin
            cur_x_d = cur_x_q + step6;
          end else begin
            busy_d = 1'b1;
            mask_d = pop_data_i.pixels;
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_d = (out_valid_q && out_stall_i) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      line_x_q    <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      scale_q     <= 8'd1;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      mask_q      <= mask_d;
      line_x_q    <= line_x_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      scale_q     <= scale_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q     <= px;
      out_y_q     <= py;
      out_size_q  <= scale_q;
      out_color_q <= color_q;
      out_last_q  <= (rest == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign square_x_o     = out_x_q;
  assign square_y_o     = out_y_q;
  assign square_size_o  = out_size_q;
  assign square_color_o = out_color_q;
  assign last_square_o  = out_last_q;

endmodule

`default_nettype wire

/* sv/font_5x7_text_rasterizer_top.sv */
// A character's first square passes the input register, item queue, square engine and
// output register. The square engine gives one square per cycle while the output is
// not stalled; a character with lit pixels holds it until its last square is loaded.
// The input side takes a beat every cycle while the item queue has room.
// Reset (async, active low): cursor, line origin and color go to zero, scale to one,
// queue and output register empty.
`default_nettype none

module font_5x7_text_rasterizer_top #(
  parameter int unsigned QueueDepth = ftr_pkg::QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic signed [15:0] origin_x_i,
  input  wire logic signed [15:0] origin_y_i,
  input  wire logic [7:0]         pixel_scale_i,
  input  wire logic [31:0]        ink_color_i,
  input  wire logic [7:0]         char_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      square_x_o,
  output logic signed [15:0]      square_y_o,
  output logic [7:0]              square_size_o,
  output logic [31:0]             square_color_o,
  output logic                    last_square_o
);
  import ftr_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  ftr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .pixel_scale_i (pixel_scale_i),
    .ink_color_i   (ink_color_i),
    .char_code_i   (char_code_i),
    .full_i        (q_full),
    .push_o        (q_push),
    .push_data_o   (q_wdata)
  );

  ftr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  ftr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .pop_data_i     (q_rdata),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .square_x_o     (square_x_o),
    .square_y_o     (square_y_o),
    .square_size_o  (square_size_o),
    .square_color_o (square_color_o),
    .last_square_o  (last_square_o)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("item queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("item queue read while empty");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled with room in the queue");
`endif

endmodule

`default_nettype wire

/* tb/tb_font_5x7_text_rasterizer_top.sv */
`default_nettype none

module tb_font_5x7_text_rasterizer_top;
  import ftr_pkg::*;

  localparam logic OpChar     = 1'b1;
  localparam int   RandItems  = 95;
  localparam int   HoldCycles = 300;
  localparam int   CycleLimit = 500000;

  typedef struct {
    logic        op;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  scale;
    logic [31:0] color;
    logic [7:0]  code;
    bit          silent;  // typed in: this beat gives no squares
  } text_beat_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         size;
    logic [31:0]        color;
    logic               last;
  } square_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               op_i;
  logic signed [15:0] origin_x_i;
  logic signed [15:0] origin_y_i;
  logic [7:0]         pixel_scale_i;
  logic [31:0]        ink_color_i;
  logic [7:0]         char_code_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] square_x_o;
  logic signed [15:0] square_y_o;
  logic [7:0]         square_size_o;
  logic [31:0]        square_color_o;
  logic               last_square_o;

  font_5x7_text_rasterizer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .pixel_scale_i (pixel_scale_i),
    .ink_color_i   (ink_color_i),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .square_x_o    (square_x_o),
    .square_y_o    (square_y_o),
    .square_size_o (square_size_o),
    .square_color_o(square_color_o),
    .last_square_o (last_square_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  square_t    pending_squares[$];
  text_beat_t directed[$];
  int         err_count   = 0;
  int         cycle_count = 0;
  bit         tx_burst    = 1'b0;
  bit         rx_eager    = 1'b0;
  bit         hold_req    = 1'b0;
  string      glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz:.-/+! ";

  // text state
  logic [15:0] line_x;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [7:0]  held_scale;
  logic [31:0] held_color;

  task automatic log_mismatch(string what);
    err_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic int char_to_glyph(logic [7:0] code);
    logic [7:0] up;
    up = (code >= CharLowerA && code <= CharLowerZ) ? code - CaseFold : code;
    if (code == CharSpace) return int'(GlyphSpace);
    if (code >= CharZero && code <= CharNine) return int'(code - CharZero);
    if (up >= CharUpperA && up <= CharUpperZ) return int'(up - CharUpperA) + int'(GlyphLetterBase);
    case (code)
      CharColon: return int'(GlyphColon);
      CharDot:   return int'(GlyphDot);
      CharDash:  return int'(GlyphDash);
      CharSlash: return int'(GlyphSlash);
      CharPlus:  return int'(GlyphPlus);
      CharBang:  return int'(GlyphBang);
      default:   return int'(GlyphUnknown);
    endcase
  endfunction

  // top row in the high bits, left column first within a row
  function automatic logic [34:0] glyph_bits(int idx);
    case (idx)
      0:  return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      1:  return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      2:  return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      3:  return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      4:  return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      5:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      6:  return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      7:  return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      8:  return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      9:  return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      10: return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      11: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      12: return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      13: return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      14: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      15: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      16: return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      17: return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      18: return {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      19: return {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      20: return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      21: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      22: return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      23: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      24: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      25: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      26: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      27: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      28: return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      29: return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      30: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      31: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      32: return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      33: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      34: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      35: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      36: return {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0};
      37: return {5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0};
      38: return {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      39: return {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      40: return {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
      41: return {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
      42: return {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};
      default: return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
    endcase
  endfunction

  // updates the text state; queues the squares unless keep is clear
  function automatic void rasterize_beat(text_beat_t b, bit keep);
    logic [34:0] g;
    square_t     sq;
    int          n;
    n = 0;
    if (b.op == OpBegin) begin
      line_x     = b.ox;
      pen_x      = b.ox;
      pen_y      = b.oy;
      held_scale = b.scale;
      held_color = b.color;
      return;
    end
    if (b.code == CharNewline) begin
      pen_x = line_x;
      pen_y = pen_y + 16'(8 * held_scale);
      return;
    end
    g = glyph_bits(char_to_glyph(b.code));
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (g[34 - 5*r - c]) begin
          sq.x     = pen_x + 16'(c * held_scale);
          sq.y     = pen_y + 16'(r * held_scale);
          sq.size  = held_scale;
          sq.color = held_color;
          sq.last  = 1'b0;
          if (keep) pending_squares.push_back(sq);
          n++;
        end
      end
    end
    if (keep && n > 0) pending_squares[pending_squares.size()-1].last = 1'b1;
    pen_x = pen_x + 16'(6 * held_scale);
  endfunction

  function automatic void add_row(logic op, logic [15:0] ox, logic [15:0] oy,
                                  logic [7:0] scale, logic [31:0] color,
                                  logic [7:0] code, bit silent);
    text_beat_t b;
    b.op     = op;
    b.ox     = ox;
    b.oy     = oy;
    b.scale  = scale;
    b.color  = color;
    b.code   = code;
    b.silent = silent;
    directed.push_back(b);
  endfunction

  function automatic text_beat_t rand_beat(logic op);
    text_beat_t b;
    int         pick;
    b.op     = op;
    b.ox     = 16'($urandom_range(0, 65535));
    b.oy     = 16'($urandom_range(0, 65535));
    b.scale  = 8'($urandom_range(1, 255));
    b.color  = $urandom;
    b.silent = 1'b0;
    pick     = $urandom_range(0, 9);
    if (op == OpBegin && pick < 2) b.scale = (pick == 0) ? 8'd1 : 8'd255;
    if (pick < 7) begin
      b.code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
    end else if (pick == 7) begin
      b.code = CharNewline;
    end else begin
      b.code = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic send_beat(text_beat_t b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i          = b.op;
    origin_x_i    = b.ox;
    origin_y_i    = b.oy;
    pixel_scale_i = b.scale;
    ink_color_i   = b.color;
    char_code_i   = b.code;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    rasterize_beat(b, !b.silent);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: per-square stall, plus one long hold-off on request
  initial begin : rx
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      n = rx_eager ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : mon
    square_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_squares.size() == 0) begin
        log_mismatch($sformatf("unexpected square x=%0d y=%0d", square_x_o, square_y_o));
      end else begin
        want = pending_squares.pop_front();
        if (square_x_o !== want.x)
          log_mismatch($sformatf("square_x %0d, want %0d", square_x_o, want.x));
        if (square_y_o !== want.y)
          log_mismatch($sformatf("square_y %0d, want %0d", square_y_o, want.y));
        if (square_size_o !== want.size)
          log_mismatch($sformatf("square_size %0d, want %0d", square_size_o, want.size));
        if (square_color_o !== want.color)
          log_mismatch($sformatf("square_color %h, want %h", square_color_o, want.color));
        if (last_square_o !== want.last)
          log_mismatch($sformatf("last_square %0b, want %0b", last_square_o, want.last));
      end
    end
  end

  initial begin : stim
    text_beat_t b;
    int         sent;
    int         n;
    bit         squeezed;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OpBegin;
    origin_x_i    = '0;
    origin_y_i    = '0;
    pixel_scale_i = 8'd1;
    ink_color_i   = '0;
    char_code_i   = '0;
    line_x        = '0;
    pen_x         = '0;
    pen_y         = '0;
    held_scale    = 8'd1;
    held_color    = '0;
    squeezed      = 1'b0;
    sent          = 0;

    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        ".",         1'b0);
    add_row(OpBegin, 16'h8000, 16'h8000, 8'd1,   32'h0,        8'd0,        1'b1);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "A",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        CharNewline, 1'b1);
    add_row(OpBegin, 16'h7fff, 16'h7fff, 8'd255, 32'hffffffff, 8'hff,       1'b1);
    add_row(OpChar,  16'hffff, 16'hffff, 8'hff,  32'hffffffff, "8",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "B",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        CharNewline, 1'b1);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        CharSpace,   1'b1);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        8'd0,        1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        8'd255,      1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "z",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        ":",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "-",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "/",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "+",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "!",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "0",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "9",         1'b0);
    add_row(OpBegin, 16'h0010, 16'hfff0, 8'd0,   32'ha5a5a5a5, 8'd0,        1'b1);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "H",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        CharNewline, 1'b1);
    add_row(OpBegin, 16'hff9c, 16'h0032, 8'd3,   32'h12345678, 8'd0,        1'b1);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        "@",         1'b0);
    add_row(OpChar,  16'h0000, 16'h0000, 8'd0,   32'h0,        8'd128,      1'b0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_beat(directed[i]);

    while (sent < RandItems) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0) begin
        send_beat(rand_beat(OpBegin));
        sent++;
      end
      n = $urandom_range(1, 12);
      if (!squeezed && sent >= 40) begin
        squeezed = 1'b1;
        hold_req = 1'b1;
        tx_burst = 1'b1;
        n        = 14;
      end
      repeat (n) begin
        b = rand_beat(OpChar);
        send_beat(b);
        sent++;
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (pending_squares.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
